// ===== design/trr_pkg.sv =====
// shared types and codes for the trace ring recorder
// no dependencies

package trr_pkg;

    // command codes
    localparam logic [2:0] CMD_SAMPLE = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;
    localparam logic [2:0] CMD_INFO   = 3'd5;

    // result status codes
    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_NOT_STOPPED = 3'd1;
    localparam logic [2:0] STS_BAD_REQ     = 3'd2;
    localparam logic [2:0] STS_ALREADY_REC = 3'd3;
    localparam logic [2:0] STS_NOT_REC     = 3'd4;
    localparam logic [2:0] STS_STOP_FIRST  = 3'd5;
    localparam logic [2:0] STS_IGNORED     = 3'd6;

    // recorder states
    localparam logic [1:0] TS_IDLE = 2'd0;
    localparam logic [1:0] TS_REC  = 2'd1;
    localparam logic [1:0] TS_STOP = 2'd2;

    localparam logic [15:0] QUALITY_MAX = 16'hFFFF;
    localparam logic [31:0] PULSE_NONE  = 32'hFFFF_FFFF;

    // decoded command item, as held in the queue
    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] now_ms;
        logic [31:0] pps_count;
        logic        pps_zero;
        logic [63:0] payload;
        logic [15:0] quality;
        logic [2:0]  flags;
        logic [31:0] from_seq;
        logic [6:0]  max_out;
    } item_t;

    // one stored ring entry
    typedef struct packed {
        logic [31:0] time_ms;
        logic [31:0] pps;
        logic [63:0] payload;
        logic [15:0] quality;
        logic [2:0]  flags;
    } rec_t;

    // one result item
    typedef struct packed {
        logic [2:0]  status;
        logic        last;
        logic [1:0]  trace_state;
        logic [31:0] next_seq;
        logic [10:0] held_count;
        logic [31:0] dropped;
        rec_t        rec;
    } rsp_t;

    function automatic rsp_t make_hdr(
        input logic [2:0]  status,
        input logic [1:0]  trace_state,
        input logic [31:0] next_seq,
        input logic [10:0] held_count,
        input logic [31:0] dropped
    );
        rsp_t r;
        r             = '0;
        r.status      = status;
        r.last        = 1'b1;
        r.trace_state = trace_state;
        r.next_seq    = next_seq;
        r.held_count  = held_count;
        r.dropped     = dropped;
        return r;
    endfunction

endpackage

// ===== design/trr_if.sv =====
// valid/ready channel interfaces for the trace ring recorder
// command channel and result channel; no dependencies

interface trr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] now_ms;
    logic [31:0] pps_count;
    logic [63:0] payload;
    logic [31:0] quality_ms;
    logic        pps_fresh;
    logic        time_valid;
    logic        temp_comp;
    logic [31:0] from_seq;
    logic [6:0]  max_out;

    modport source (
        output valid, cmd, now_ms, pps_count, payload, quality_ms,
               pps_fresh, time_valid, temp_comp, from_seq, max_out,
        input  ready
    );
    modport sink (
        input  valid, cmd, now_ms, pps_count, payload, quality_ms,
               pps_fresh, time_valid, temp_comp, from_seq, max_out,
        output ready
    );
endinterface

interface trr_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        last;
    logic [1:0]  trace_state;
    logic [31:0] next_seq;
    logic [10:0] held_count;
    logic [31:0] dropped;
    logic [31:0] rec_time_ms;
    logic [31:0] rec_pps;
    logic [63:0] rec_payload;
    logic [15:0] rec_quality;
    logic [2:0]  rec_flags;

    modport source (
        output valid, status, last, trace_state, next_seq, held_count,
               dropped, rec_time_ms, rec_pps, rec_payload, rec_quality,
               rec_flags,
        input  ready
    );
    modport sink (
        input  valid, status, last, trace_state, next_seq, held_count,
               dropped, rec_time_ms, rec_pps, rec_payload, rec_quality,
               rec_flags,
        output ready
    );
endinterface

// ===== design/trr_front.sv =====
// command front end: decodes items and holds them in a two-entry queue
// depends on trr_pkg and trr_req_if

module trr_front
    import trr_pkg::*;
#(
    parameter int MAX_READ = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    trr_req_if.sink    req,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    localparam logic [6:0] MAX_RD = 7'(MAX_READ);

    item_t       dec;
    item_t       q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push;

    always_comb
    begin
        dec.cmd       = req.cmd;
        dec.now_ms    = req.now_ms;
        dec.pps_count = req.pps_count;
        dec.pps_zero  = (req.pps_count == 32'd0);
        dec.payload   = req.payload;
        dec.quality   = (req.quality_ms > 32'(QUALITY_MAX)) ? QUALITY_MAX
                                                            : req.quality_ms[15:0];
        dec.flags     = {req.temp_comp, req.time_valid, req.pps_fresh};
        dec.from_seq  = req.from_seq;
        dec.max_out   = (req.max_out > MAX_RD) ? MAX_RD : req.max_out;
    end

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (fill_reg != 2'd0);
    assign q_item    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue fill out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

// ===== design/trr_back.sv =====
// command back end: recorder state, ring memory, read sequencer, result register
// depends on trr_pkg and trr_rsp_if

module trr_back
    import trr_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    trr_rsp_if.source  rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W:0]   CAP_SUM  = (CNT_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_EXEC  = 3'd1;
    localparam logic [2:0] B_CLAMP = 3'd2;
    localparam logic [2:0] B_CHECK = 3'd3;
    localparam logic [2:0] B_INDEX = 3'd4;
    localparam logic [2:0] B_ISSUE = 3'd5;
    localparam logic [2:0] B_EMIT  = 3'd6;

    rec_t                 mem [CAPACITY];
    rec_t                 rdata_reg;

    logic [2:0]           fsm_reg, fsm_next;
    item_t                cur_reg, cur_next;
    logic [1:0]           tstate_reg, tstate_next;
    logic [IDX_W-1:0]     oldest_reg, oldest_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [31:0]          drop_reg, drop_next;
    logic [31:0]          nseq_reg, nseq_next;
    logic [31:0]          last_pulse_reg, last_pulse_next;
    logic [31:0]          from_reg, from_next;
    logic [31:0]          first_reg, first_next;
    logic [6:0]           left_reg, left_next;
    logic [CNT_W-1:0]     off_reg, off_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_reg, out_next;

    logic                 emit_ok;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    rec_t                 mem_wdata;
    logic [CNT_W-1:0]     addend;
    logic [CNT_W:0]       sum;
    logic [IDX_W-1:0]     wrap_idx;
    logic [CNT_W+10:0]    cnt_wide;
    logic [10:0]          held11;
    logic [31:0]          first_calc;
    logic [31:0]          rem;
    logic [2:0]           status;

    function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] v);
        return (v == IDX_LAST) ? '0 : v + 1'b1;
    endfunction

    // oldest plus an offset, folded back into the ring
    assign addend   = (fsm_reg == B_INDEX) ? off_reg : count_reg;
    assign sum      = (CNT_W + 1)'(oldest_reg) + {1'b0, addend};
    assign wrap_idx = (sum >= CAP_SUM) ? IDX_W'(sum - CAP_SUM) : IDX_W'(sum);

    assign cnt_wide   = {11'b0, count_next};
    assign held11     = cnt_wide[10:0];
    assign first_calc = nseq_reg - 32'(count_reg);
    assign rem        = nseq_reg - from_reg;
    assign emit_ok    = !out_valid_reg || rsp.ready;

    assign mem_wdata.time_ms = cur_reg.now_ms;
    assign mem_wdata.pps     = cur_reg.pps_count;
    assign mem_wdata.payload = cur_reg.payload;
    assign mem_wdata.quality = cur_reg.quality;
    assign mem_wdata.flags   = cur_reg.flags;

    always_comb
    begin
        fsm_next        = fsm_reg;
        cur_next        = cur_reg;
        tstate_next     = tstate_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        drop_next       = drop_reg;
        nseq_next       = nseq_reg;
        last_pulse_next = last_pulse_reg;
        from_next       = from_reg;
        first_next      = first_reg;
        left_next       = left_reg;
        off_next        = off_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_next        = out_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = oldest_reg;
        status          = STS_OK;

        case (fsm_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    fsm_next = B_EXEC;
                end
            end

            B_EXEC:
            begin
                if (cur_reg.cmd == CMD_READ && cur_reg.max_out != 7'd0 &&
                    tstate_reg == TS_STOP && count_reg != '0)
                begin
                    fsm_next = B_CLAMP;
                end
                else if (emit_ok)
                begin
                    case (cur_reg.cmd)
                        CMD_SAMPLE:
                        begin
                            if (tstate_reg == TS_REC && !cur_reg.pps_zero &&
                                cur_reg.pps_count != last_pulse_reg)
                            begin
                                last_pulse_next = cur_reg.pps_count;
                                mem_we          = 1'b1;
                                nseq_next       = nseq_reg + 32'd1;
                                if (count_reg < CAP_CNT)
                                begin
                                    mem_waddr  = wrap_idx;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    // full: overwrite the oldest entry
                                    oldest_next = inc_wrap(oldest_reg);
                                    drop_next   = drop_reg + 32'd1;
                                end
                            end
                            else
                            begin
                                status = STS_IGNORED;
                            end
                        end
                        CMD_START, CMD_CLEAR:
                        begin
                            if (tstate_reg == TS_REC)
                            begin
                                status = (cur_reg.cmd == CMD_START) ? STS_ALREADY_REC
                                                                    : STS_STOP_FIRST;
                            end
                            else
                            begin
                                oldest_next     = '0;
                                count_next      = '0;
                                drop_next       = 32'd0;
                                nseq_next       = 32'd0;
                                last_pulse_next = PULSE_NONE;
                                tstate_next     = (cur_reg.cmd == CMD_START) ? TS_REC
                                                                             : TS_IDLE;
                            end
                        end
                        CMD_STOP:
                        begin
                            if (tstate_reg == TS_REC)
                            begin
                                tstate_next = TS_STOP;
                            end
                            else if (tstate_reg != TS_STOP)
                            begin
                                status = STS_NOT_REC;
                            end
                        end
                        CMD_READ:
                        begin
                            status = (cur_reg.max_out == 7'd0 || tstate_reg == TS_STOP)
                                     ? STS_BAD_REQ : STS_NOT_STOPPED;
                        end
                        CMD_INFO:
                        begin
                            status = STS_OK;
                        end
                        default:
                        begin
                            status = STS_BAD_REQ;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    out_next       = make_hdr(status, tstate_next,
                        (cur_reg.cmd == CMD_READ) ? cur_reg.from_seq : nseq_next,
                        held11, drop_next);
                    fsm_next       = B_IDLE;
                end
            end

            B_CLAMP:
            begin
                first_next = first_calc;
                from_next  = (cur_reg.from_seq < first_calc) ? first_calc
                                                              : cur_reg.from_seq;
                fsm_next   = B_CHECK;
            end

            B_CHECK:
            begin
                if (from_reg >= nseq_reg)
                begin
                    // start lies past the newest entry
                    if (emit_ok)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = make_hdr(STS_OK, tstate_reg, nseq_reg,
                                                  held11, drop_reg);
                        fsm_next       = B_IDLE;
                    end
                end
                else
                begin
                    left_next = (rem < 32'(cur_reg.max_out)) ? rem[6:0] : cur_reg.max_out;
                    off_next  = CNT_W'(from_reg - first_reg);
                    fsm_next  = B_INDEX;
                end
            end

            B_INDEX:
            begin
                idx_next = wrap_idx;
                fsm_next = B_ISSUE;
            end

            B_ISSUE:
            begin
                fsm_next = B_EMIT;
            end

            B_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_next       = make_hdr(STS_OK, tstate_reg, from_reg + 32'd1,
                                              held11, drop_reg);
                    out_next.rec   = rdata_reg;
                    out_next.last  = (left_reg == 7'd1);
                    from_next      = from_reg + 32'd1;
                    left_next      = left_reg - 7'd1;
                    idx_next       = inc_wrap(idx_reg);
                    fsm_next       = (left_reg == 7'd1) ? B_IDLE : B_ISSUE;
                end
            end

            default:
            begin
                fsm_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        from_reg  <= from_next;
        first_reg <= first_next;
        left_reg  <= left_next;
        off_reg   <= off_next;
        idx_reg   <= idx_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= B_IDLE;
            tstate_reg     <= TS_IDLE;
            oldest_reg     <= '0;
            count_reg      <= '0;
            drop_reg       <= 32'd0;
            nseq_reg       <= 32'd0;
            last_pulse_reg <= PULSE_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            tstate_reg     <= tstate_next;
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            drop_reg       <= drop_next;
            nseq_reg       <= nseq_next;
            last_pulse_reg <= last_pulse_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.last        = out_reg.last;
    assign rsp.trace_state = out_reg.trace_state;
    assign rsp.next_seq    = out_reg.next_seq;
    assign rsp.held_count  = out_reg.held_count;
    assign rsp.dropped     = out_reg.dropped;
    assign rsp.rec_time_ms = out_reg.rec.time_ms;
    assign rsp.rec_pps     = out_reg.rec.pps;
    assign rsp.rec_payload = out_reg.rec.payload;
    assign rsp.rec_quality = out_reg.rec.quality;
    assign rsp.rec_flags   = out_reg.rec.flags;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("ring count above capacity");

    a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oldest_reg <= IDX_LAST)
        else $error("oldest index outside ring");

    a_read_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == B_ISSUE || fsm_reg == B_EMIT) |-> tstate_reg == TS_STOP)
        else $error("read sequencer active while not stopped");

    a_write_when_rec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (tstate_reg == TS_REC && emit_ok))
        else $error("ring written outside recording");

endmodule

// ===== design/trace_ring_recorder_core.sv =====
// top level of the trace ring recorder
// depends on trr_pkg, trr_if, trr_front and trr_back
//
//   channel | dir | handshake     | carries
//   req     | in  | valid/ready   | cmd, sample fields, read request
//   rsp     | out | valid/ready   | status, counters, up to one record per item
//
// non-read commands: popped from the queue, then executed in B_EXEC once rsp can take the result
// reads: setup in B_EXEC, B_CLAMP, B_CHECK, B_INDEX, then B_ISSUE and B_EMIT per record (ring memory read port)
// the front queue holds two commands behind the one in the back end, then req stalls
// reset clears the recorder state and counters; the ring memory is not cleared
// a stalled rsp holds its result register; the back end waits in each state that emits a result

module trace_ring_recorder_core
    import trr_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int MAX_READ = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    trr_req_if.sink    req,
    trr_rsp_if.source  rsp
);

    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    trr_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    trr_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule
